// File: rtl/bre_pkg.sv
// ----------------------------------------------------------------------------
// bre_pkg: shared types and constants of the BER REAL encoder
// Holds the queue entry format passed from the classifier to the serializer.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [10:0] EXPF_ALL_ONES = 11'h7ff;
    localparam logic signed [11:0] EXP_BIAS = 12'sd1075;
    localparam logic signed [11:0] EXP_SUBN = -12'sd1074;

    localparam logic [7:0] BYTE_SPEC_POS = 8'h40;
    localparam logic [7:0] BYTE_SPEC_NEG = 8'h41;
    localparam logic [7:0] BYTE_HDR_BIN  = 8'h80;
    localparam logic [7:0] BYTE_HDR_SIGN = 8'h40;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_SPEC,
        KIND_NUM
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic signed [11:0] ex;
        logic [52:0]        mant;
        logic [2:0]         mlen;
        logic               elen2;
        logic [3:0]         clen;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: rtl/bre_front.sv
// ----------------------------------------------------------------------------
// bre_front: input classifier
// Decodes the double, strips trailing zeros of the mantissa in two halves
// around one register, and sizes the exponent, mantissa and content.
// ----------------------------------------------------------------------------
module bre_front import bre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value_bits,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_entry      o_entry
);

    logic               r_valid;
    t_kind              r_kind;
    logic               r_neg;
    logic signed [11:0] r_ex;
    logic [52:0]        r_mant;

    logic [10:0]        expf;
    logic [51:0]        frac;
    t_kind              n_kind;
    logic               n_neg;
    logic signed [11:0] n_ex;
    logic [52:0]        n_mant;
    logic               accept;

    logic signed [11:0] ex_f;
    logic [52:0]        mant_f;
    logic [2:0]         mlen;
    logic               elen2;

    assign o_push     = r_valid && !i_qstat.full;
    assign o_in_stall = r_valid && i_qstat.full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        expf  = i_value_bits[62:52];
        frac  = i_value_bits[51:0];
        n_neg = i_value_bits[63];
        if (expf == EXPF_ALL_ONES) begin
            n_kind = KIND_SPEC;
            n_neg  = i_value_bits[63] && (frac == '0);
        end else if (expf == '0 && frac == '0) begin
            n_kind = KIND_ZERO;
        end else begin
            n_kind = KIND_NUM;
        end
        if (expf == '0) begin
            n_mant = {1'b0, frac};
            n_ex   = EXP_SUBN;
        end else begin
            n_mant = {1'b1, frac};
            n_ex   = $signed({1'b0, expf}) - EXP_BIAS;
        end
        if (n_mant != '0) begin
            if (n_mant[31:0] == '0) begin
                n_mant = n_mant >> 32;
                n_ex   = n_ex + 12'sd32;
            end
            if (n_mant[15:0] == '0) begin
                n_mant = n_mant >> 16;
                n_ex   = n_ex + 12'sd16;
            end
            if (n_mant[7:0] == '0) begin
                n_mant = n_mant >> 8;
                n_ex   = n_ex + 12'sd8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_kind <= n_kind;
            r_neg  <= n_neg;
            r_ex   <= n_ex;
            r_mant <= n_mant;
        end
    end

    always_comb begin
        mant_f = r_mant;
        ex_f   = r_ex;
        if (mant_f != '0) begin
            if (mant_f[3:0] == '0) begin
                mant_f = mant_f >> 4;
                ex_f   = ex_f + 12'sd4;
            end
            if (mant_f[1:0] == '0) begin
                mant_f = mant_f >> 2;
                ex_f   = ex_f + 12'sd2;
            end
            if (mant_f[0] == 1'b0) begin
                mant_f = mant_f >> 1;
                ex_f   = ex_f + 12'sd1;
            end
        end
        mlen = 3'd7;
        for (int m = 6; m >= 1; m--) begin
            if ((mant_f >> (8 * m - 1)) == '0) begin
                mlen = 3'(m);
            end
        end
        elen2 = !(ex_f[11:7] == 5'b00000 || ex_f[11:7] == 5'b11111);

        o_entry.kind  = r_kind;
        o_entry.neg   = r_neg;
        o_entry.ex    = ex_f;
        o_entry.mant  = mant_f;
        o_entry.mlen  = mlen;
        o_entry.elen2 = elen2;
        case (r_kind)
            KIND_ZERO: o_entry.clen = 4'd0;
            KIND_SPEC: o_entry.clen = 4'd1;
            KIND_NUM:  o_entry.clen = 4'd2 + {3'b000, elen2} + {1'b0, mlen};
            default:   o_entry.clen = 4'd0;
        endcase
    end

endmodule

// File: rtl/bre_queue.sv
// ----------------------------------------------------------------------------
// bre_queue: short entry queue
// Decouples the classifier from the byte serializer.
// ----------------------------------------------------------------------------
module bre_queue import bre_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_entry o_head
);

    t_entry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// File: rtl/bre_back.sv
// ----------------------------------------------------------------------------
// bre_back: byte serializer
// Walks the queue head one byte per unstalled cycle into a registered output.
// ----------------------------------------------------------------------------
module bre_back import bre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qstat     i_qstat,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [3:0] r_idx;

    logic        advance;
    logic        load;
    logic        n_last;
    logic [7:0]  n_byte;
    logic [15:0] ex16;
    logic [55:0] mant56;
    logic [2:0]  mbyte;
    logic [3:0]  mant_start;

    assign advance = !r_valid || !i_out_stall;
    assign load    = advance && !i_qstat.empty;
    assign n_last  = (r_idx == i_head.clen);
    assign o_pop   = load && n_last;

    always_comb begin
        ex16       = {{4{i_head.ex[11]}}, i_head.ex};
        mant56     = {3'b000, i_head.mant};
        mant_start = 4'd2 + {3'b000, i_head.elen2} + 4'd1;
        mbyte      = 3'(i_head.clen - r_idx);
        n_byte     = '0;
        if (r_idx == '0) begin
            n_byte = {4'h0, i_head.clen};
        end else if (i_head.kind == KIND_SPEC) begin
            n_byte = i_head.neg ? BYTE_SPEC_NEG : BYTE_SPEC_POS;
        end else if (r_idx == 4'd1) begin
            n_byte = BYTE_HDR_BIN | (i_head.neg ? BYTE_HDR_SIGN : 8'h00)
                   | {7'b0000000, i_head.elen2};
        end else if (r_idx < mant_start) begin
            if (i_head.elen2 && r_idx == 4'd2) begin
                n_byte = ex16[15:8];
            end else begin
                n_byte = ex16[7:0];
            end
        end else begin
            n_byte = 8'(mant56 >> {mbyte, 3'b000});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (advance) begin
            r_valid <= load;
            if (load) begin
                r_idx <= n_last ? '0 : r_idx + 1'b1;
            end
        end
        if (load) begin
            r_byte <= n_byte;
            r_last <= n_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;

endmodule

// File: rtl/ber_real_encoder.sv
// ----------------------------------------------------------------------------
// ber_real_encoder: BER REAL binary encoder for IEEE-754 doubles
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_value_bits[63:0]
//   out      output     o_out_valid / i_out_stall o_out_byte[7:0], o_last
//
// Each value yields one to eleven bytes, one byte per cycle from the
// serializer while the receiver does not stall. The first byte passes
// the classifier register, the queue and the serializer register.
// The classifier and serializer meet at a two-entry queue and stall apart.
// Reset is synchronous, active low, and empties all stages.
// ----------------------------------------------------------------------------
module ber_real_encoder import bre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_value_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    t_qstat qstat;
    t_entry push_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;

    bre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value_bits (i_value_bits),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    bre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head_entry)
    );

    bre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_head      (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("queue written while full");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("queue read while empty");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_out_valid && o_last)
        else $error("entry retired without a final byte");
`endif

endmodule

// File: tb/sv/ber_real_checker.sv
// ----------------------------------------------------------------------------
// ber_real_checker: scoreboard for the BER REAL encoder
// Watches the input and output channels. For every accepted double it works
// out the expected BER REAL byte string. Each byte that leaves the encoder
// is compared with the oldest expected byte, including its last flag.
// ----------------------------------------------------------------------------
module ber_real_checker import bre_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_value_bits,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] EXP_LEN_ONE = 8'h00;
    localparam logic [7:0] EXP_LEN_TWO = 8'h01;
    localparam int         REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_wire_byte;

    t_wire_byte expected_bytes [$];
    int         mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_bytes.size();

    function automatic void predict_ber_real(input logic [63:0] bits);
        logic [10:0] expf;
        logic [51:0] frac;
        logic        neg;
        logic [7:0]  content [10];
        int          clen;
        logic [63:0] mant;
        int          ex;
        int          mlen;
        logic        two_byte_exp;
        t_wire_byte  wb;
        expf = bits[62:52];
        frac = bits[51:0];
        neg  = bits[63];
        clen = 0;
        if (expf == EXPF_ALL_ONES) begin
            content[0] = (neg && frac == '0) ? BYTE_SPEC_NEG : BYTE_SPEC_POS;
            clen = 1;
        end else if (expf != '0 || frac != '0) begin
            if (expf == '0) begin
                mant = {12'd0, frac};
                ex   = EXP_SUBN;
            end else begin
                mant = {11'd0, 1'b1, frac};
                ex   = int'(expf) - EXP_BIAS;
            end
            while (mant[0] == 1'b0) begin
                mant = mant >> 1;
                ex++;
            end
            mlen = 1;
            while (mlen < 8 && (mant >> (8 * mlen - 1)) != '0) begin
                mlen++;
            end
            two_byte_exp = !(ex >= -128 && ex <= 127);
            content[0] = BYTE_HDR_BIN | (neg ? BYTE_HDR_SIGN : 8'h00)
                | (two_byte_exp ? EXP_LEN_TWO : EXP_LEN_ONE);
            clen = 1;
            if (two_byte_exp) begin
                content[clen] = ex[15:8];
                clen++;
            end
            content[clen] = ex[7:0];
            clen++;
            for (int i = mlen - 1; i >= 0; i--) begin
                content[clen] = mant[8 * i +: 8];
                clen++;
            end
        end
        wb.data = clen[7:0];
        wb.last = (clen == 0);
        expected_bytes.push_back(wb);
        for (int i = 0; i < clen; i++) begin
            wb.data = content[i];
            wb.last = (i == clen - 1);
            expected_bytes.push_back(wb);
        end
    endfunction

    always @(posedge i_clk) begin
        t_wire_byte wb;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                predict_ber_real(i_value_bits);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("%0t: unexpected byte %02h last %0b", $realtime,
                            i_out_byte, i_last);
                    end
                    mismatches++;
                end else begin
                    wb = expected_bytes.pop_front();
                    if (wb.data !== i_out_byte || wb.last !== i_last) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("%0t: byte expected %02h last %0b, got %02h last %0b",
                                $realtime, wb.data, wb.last, i_out_byte, i_last);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the BER REAL encoder
// Drives doubles into the encoder, first a directed set of corner values,
// then random values shaped toward special classes and exponent and
// mantissa length boundaries. Both sides idle at random in the first two
// of three phases, and the receiver holds off once for a long stretch to
// fill the encoder. A separate checker predicts and compares the output bytes.
// ----------------------------------------------------------------------------
module testbench;
    import bre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_BYTE   = 80;
    localparam int RANDOM_PER_PHASE = 45;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic [63:0] DIRECTED [25] = '{
        64'h0000_0000_0000_0000,   // positive zero
        64'h8000_0000_0000_0000,   // negative zero
        64'h7FF0_0000_0000_0000,   // positive infinity
        64'hFFF0_0000_0000_0000,   // negative infinity
        64'h7FF8_0000_0000_0000,   // quiet NaN
        64'hFFF8_0000_0000_0000,   // quiet NaN with the sign bit set
        64'hFFF0_0000_0000_0001,   // signaling NaN with the sign bit set
        64'h0000_0000_0000_0001,   // smallest subnormal
        64'h000F_FFFF_FFFF_FFFF,   // largest subnormal
        64'h8008_0000_0000_0000,   // negative subnormal, single fraction bit
        64'h0010_0000_0000_0000,   // smallest normal
        64'h7FEF_FFFF_FFFF_FFFF,   // largest finite
        64'hFFEF_FFFF_FFFF_FFFF,   // most negative finite
        64'h3FF0_0000_0000_0000,   // 1.0
        64'hBFF0_0000_0000_0000,   // -1.0
        64'h3FE0_0000_0000_0000,   // 0.5
        64'h37F0_0000_0000_0000,   // 2^-128, one exponent byte
        64'h37E0_0000_0000_0000,   // 2^-129, two exponent bytes
        64'h47E0_0000_0000_0000,   // 2^127, one exponent byte
        64'h47F0_0000_0000_0000,   // 2^128, two exponent bytes
        64'h405F_C000_0000_0000,   // 127.0, one mantissa byte
        64'h406F_E000_0000_0000,   // 255.0, top bit forces a second byte
        64'h3FFF_FFFF_FFFF_FFFF,   // full mantissa, seven bytes
        64'h4009_21FB_5444_2D18,   // pi
        64'hC1D2_3456_789A_BCDF    // negative, mixed bits
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [63:0] value_bits = '0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;

    int fail_count;
    int pending;
    int send_idle_pct = 32;
    int recv_idle_pct = 72;
    int bytes_taken = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    ber_real_encoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_value_bits (value_bits),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    ber_real_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_value_bits (value_bits),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (o_out_byte),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken == HOLD_AT_BYTE) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
        if (i_rst_n && o_out_valid && !out_stall) begin
            bytes_taken <= bytes_taken + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_double(input logic [63:0] bits);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        value_bits <= bits;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] bits;
        int          kind;
        bits = {$urandom, $urandom};
        kind = $urandom_range(99);
        if (kind < 10) begin
            bits[62:52] = '0;
            bits[51:0]  = bits[51:0] >> $urandom_range(51);
        end else if (kind < 16) begin
            bits[62:52] = EXPF_ALL_ONES;
            if ($urandom_range(1) == 0) begin
                bits[51:0] = '0;
            end
        end else if (kind < 19) begin
            bits[62:0] = '0;
        end else if (kind < 25) begin
            bits[51:0] = '0;
        end else if (kind < 40) begin
            bits[62:52] = ($urandom_range(1) == 0) ? 11'd893 + 11'($urandom_range(6))
                                                    : 11'd1147 + 11'($urandom_range(6));
            bits[51:0]  = bits[51:0] << $urandom_range(52);
        end else if (kind < 70) begin
            bits[51:0] = bits[51:0] << $urandom_range(52);
        end
        return bits;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED[i]) begin
            send_double(DIRECTED[i]);
        end
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 32 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_double(random_double());
            end
        end
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
